FILE: src/mrb_pkg.sv
package mrb_pkg;

  // converter resolution; the sample field carries up to SAMPLE_W bits
  localparam int SAMPLE_BITS = 10;

  localparam int CMD_W      = 4;
  localparam int SAMPLE_W   = 10;
  localparam int DIGIT_W    = 4;
  localparam int UNIT_W     = 2;
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;

  localparam longint unsigned FULL_SCALE  = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam longint unsigned READING_MAX = 64'd99999;
  localparam int              READ_W      = $clog2(READING_MAX + 64'd1);

  // q16 gains in hundredths of the display unit per count
  localparam int              GAIN_FRAC = 16;
  localparam longint unsigned VDEN      = 64'd4 * 64'd51 * FULL_SCALE;
  localparam longint unsigned ADEN      = VDEN * 64'd220;

  localparam longint unsigned GAIN_DCV_5   = ((64'd5 * 64'd10051 * 64'd9) << GAIN_FRAC) / VDEN;
  localparam longint unsigned GAIN_DCV_50  = ((64'd5 * 64'd10051 * 64'd27) << GAIN_FRAC) / VDEN;
  localparam longint unsigned GAIN_DCV_200 = ((64'd5 * 64'd10051 * 64'd101) << GAIN_FRAC) / VDEN;
  localparam longint unsigned GAIN_ACV_5   =
    ((64'd5 * 64'd10051 * 64'd9 * 64'd227) << GAIN_FRAC) / ADEN;
  localparam longint unsigned GAIN_ACV_50  =
    ((64'd5 * 64'd10051 * 64'd27 * 64'd227) << GAIN_FRAC) / ADEN;
  localparam longint unsigned GAIN_ACV_200 =
    ((64'd5 * 64'd10051 * 64'd101 * 64'd227) << GAIN_FRAC) / ADEN;
  localparam longint unsigned GAIN_DC_MA   = (64'd100350 << GAIN_FRAC) / FULL_SCALE;
  localparam longint unsigned GAIN_AC_MA   =
    ((64'd100000 * 64'd227) << GAIN_FRAC) / (64'd220 * FULL_SCALE);

  // resistance numerator constants
  localparam longint unsigned R10K_K = 64'd135;
  localparam longint unsigned R1M_K  = 64'd150035;

  function automatic longint unsigned max_u64(longint unsigned a, longint unsigned b);
    return (a > b) ? a : b;
  endfunction

  localparam longint unsigned MAX_K =
    max_u64(max_u64(GAIN_ACV_200, GAIN_DC_MA), max_u64(GAIN_AC_MA, R1M_K));
  localparam int K_W          = $clog2(MAX_K + 64'd1);
  localparam int PROD_W       = SAMPLE_BITS + K_W;
  localparam int DEN_SHIFT_W  = SAMPLE_BITS + READ_W;
  localparam int CMP_W        = (PROD_W > DEN_SHIFT_W) ? PROD_W : DEN_SHIFT_W;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int BCD_STEPS    = 4;
  localparam int BCD_STAGES   = (READ_W + BCD_STEPS - 1) / BCD_STEPS;

  typedef enum logic [CMD_W-1:0] {
    MODE_DCV_5   = 4'd0,
    MODE_DCV_50  = 4'd1,
    MODE_DCV_200 = 4'd2,
    MODE_ACV_5   = 4'd3,
    MODE_ACV_50  = 4'd4,
    MODE_ACV_200 = 4'd5,
    MODE_DC_MA   = 4'd6,
    MODE_AC_MA   = 4'd7,
    MODE_R10K    = 4'd8,
    MODE_R1M     = 4'd9
  } mode_t;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_VOLT = 2'd0,
    UNIT_MA   = 2'd1,
    UNIT_KOHM = 2'd2
  } unit_t;

  typedef enum logic [1:0] {
    KIND_GAIN,
    KIND_RES,
    KIND_BAD
  } kind_t;

  // queue entry between the front and the back
  typedef struct packed {
    kind_t                  kind;
    unit_t                  unit;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS-1:0] den;
  } item_t;

  typedef struct packed {
    unit_t                  unit;
    logic                   res;
    logic                   bad;
    logic                   sat;
    logic [CMP_W-1:0]       rem;
    logic [SAMPLE_BITS-1:0] den;
    logic [READ_W-1:0]      quo;
  } div_t;

  typedef struct packed {
    unit_t             unit;
    logic              ovf;
    logic [BCD_W-1:0]  bcd;
    logic [READ_W-1:0] bin;
  } bcd_t;

  function automatic logic [K_W-1:0] mode_coef(mode_t m);
    logic [K_W-1:0] k;
    unique case (m)
      MODE_DCV_5:   k = K_W'(GAIN_DCV_5);
      MODE_DCV_50:  k = K_W'(GAIN_DCV_50);
      MODE_DCV_200: k = K_W'(GAIN_DCV_200);
      MODE_ACV_5:   k = K_W'(GAIN_ACV_5);
      MODE_ACV_50:  k = K_W'(GAIN_ACV_50);
      MODE_ACV_200: k = K_W'(GAIN_ACV_200);
      MODE_DC_MA:   k = K_W'(GAIN_DC_MA);
      MODE_AC_MA:   k = K_W'(GAIN_AC_MA);
      MODE_R10K:    k = K_W'(R10K_K);
      MODE_R1M:     k = K_W'(R1M_K);
      default:      k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: src/mrb_in_if.sv
interface mrb_in_if;
  logic                          valid;
  logic                          ready;
  logic [mrb_pkg::CMD_W-1:0]     command;
  logic [mrb_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

FILE: src/mrb_out_if.sv
interface mrb_out_if;
  logic                         valid;
  logic                         ready;
  logic [mrb_pkg::DIGIT_W-1:0]  hundreds_digit;
  logic [mrb_pkg::DIGIT_W-1:0]  tens_digit;
  logic [mrb_pkg::DIGIT_W-1:0]  ones_digit;
  logic [mrb_pkg::DIGIT_W-1:0]  tenths_digit;
  logic [mrb_pkg::DIGIT_W-1:0]  hundredths_digit;
  logic [mrb_pkg::UNIT_W-1:0]   unit_code;
  logic                         overflow;

  modport source (output valid, output hundreds_digit, output tens_digit, output ones_digit,
                  output tenths_digit, output hundredths_digit, output unit_code,
                  output overflow, input ready);
  modport sink   (input valid, input hundreds_digit, input tens_digit, input ones_digit,
                  input tenths_digit, input hundredths_digit, input unit_code,
                  input overflow, output ready);
endinterface

FILE: src/mrb_front.sv
module mrb_front (
  input  logic           clk,
  input  logic           rst,
  mrb_in_if.sink         sample_ch,
  output mrb_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);

  mrb_pkg::mode_t                  mode;
  logic [mrb_pkg::SAMPLE_BITS-1:0] s;
  logic [mrb_pkg::K_W-1:0]         coef;
  mrb_pkg::kind_t                  kind;
  mrb_pkg::unit_t                  unit;
  mrb_pkg::item_t                  item_next;
  logic                            accept;

  assign mode = mrb_pkg::mode_t'(sample_ch.command);
  assign s    = mrb_pkg::SAMPLE_BITS'(sample_ch.sample);
  assign coef = mrb_pkg::mode_coef(mode);

  always_comb begin
    unique case (mode)
      mrb_pkg::MODE_DCV_5, mrb_pkg::MODE_DCV_50, mrb_pkg::MODE_DCV_200,
      mrb_pkg::MODE_ACV_5, mrb_pkg::MODE_ACV_50, mrb_pkg::MODE_ACV_200: begin
        kind = mrb_pkg::KIND_GAIN;
        unit = mrb_pkg::UNIT_VOLT;
      end
      mrb_pkg::MODE_DC_MA, mrb_pkg::MODE_AC_MA: begin
        kind = mrb_pkg::KIND_GAIN;
        unit = mrb_pkg::UNIT_MA;
      end
      mrb_pkg::MODE_R10K, mrb_pkg::MODE_R1M: begin
        kind = mrb_pkg::KIND_RES;
        unit = mrb_pkg::UNIT_KOHM;
      end
      default: begin
        kind = mrb_pkg::KIND_BAD;
        unit = mrb_pkg::UNIT_VOLT;
      end
    endcase
  end

  // one multiplier serves both the gain and the resistance numerator
  always_comb begin
    item_next.kind = kind;
    item_next.unit = unit;
    item_next.prod = mrb_pkg::PROD_W'(s) * mrb_pkg::PROD_W'(coef);
    item_next.den  = mrb_pkg::SAMPLE_BITS'(mrb_pkg::FULL_SCALE) - s;
  end

  assign sample_ch.ready = !item_valid || item_ready;
  assign accept          = sample_ch.valid && sample_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      item_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

FILE: src/mrb_queue.sv
module mrb_queue (
  input  logic           clk,
  input  logic           rst,
  input  mrb_pkg::item_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output mrb_pkg::item_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  mrb_pkg::item_t                  mem [mrb_pkg::QUEUE_DEPTH];
  logic [mrb_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [mrb_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [mrb_pkg::QUEUE_CNT_W-1:0] count;
  logic                            push;
  logic                            pop;

  assign push_ready = count != mrb_pkg::QUEUE_CNT_W'(mrb_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: src/mrb_back.sv
module mrb_back (
  input  logic           clk,
  input  logic           rst,
  input  mrb_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  mrb_out_if.source      reading_ch
);

  localparam int RW = mrb_pkg::READ_W;
  localparam int NB = mrb_pkg::BCD_STAGES;

  logic                  advance;
  mrb_pkg::div_t         prep_next;
  mrb_pkg::div_t         prep;
  logic                  prep_valid;
  logic [mrb_pkg::CMP_W-1:0] gain_rd;

  mrb_pkg::div_t         div_src   [RW];
  mrb_pkg::div_t         div_next  [RW];
  mrb_pkg::div_t         div_stage [RW];
  logic [RW-1:0]         div_src_v;
  logic [RW-1:0]         div_v;

  mrb_pkg::div_t         div_last;
  logic                  over;
  mrb_pkg::bcd_t         bcd_first;

  mrb_pkg::bcd_t         bcd_src   [NB];
  mrb_pkg::bcd_t         bcd_next  [NB];
  mrb_pkg::bcd_t         bcd_stage [NB];
  logic [NB-1:0]         bcd_src_v;
  logic [NB-1:0]         bcd_v;

  mrb_pkg::bcd_t         res_q;

  // the whole back pipeline moves together; the last stage is the output register
  assign advance    = !bcd_v[NB-1] || reading_ch.ready;
  assign item_ready = advance;

  // classify overflow early and load the divider
  always_comb begin
    gain_rd        = mrb_pkg::CMP_W'(item.prod) >> mrb_pkg::GAIN_FRAC;
    prep_next.unit = item.unit;
    prep_next.res  = item.kind == mrb_pkg::KIND_RES;
    prep_next.bad  = item.kind == mrb_pkg::KIND_BAD;
    prep_next.rem  = mrb_pkg::CMP_W'(item.prod);
    prep_next.den  = item.den;
    priority if (item.kind == mrb_pkg::KIND_RES) begin
      // quotient must fit the divider width, else it is out of range anyway
      prep_next.sat = (item.den == '0) ||
                      (mrb_pkg::CMP_W'(item.prod) >= (mrb_pkg::CMP_W'(item.den) << RW));
      prep_next.quo = '0;
    end else begin
      prep_next.sat = gain_rd > mrb_pkg::CMP_W'(mrb_pkg::READING_MAX);
      prep_next.quo = RW'(gain_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (advance) begin
      prep_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prep <= prep_next;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar d = 0; d < RW; d++) begin : g_div
    localparam int SH = RW - 1 - d;

    if (d == 0) begin : g_head
      assign div_src[d]   = prep;
      assign div_src_v[d] = prep_valid;
    end else begin : g_link
      assign div_src[d]   = div_stage[d-1];
      assign div_src_v[d] = div_v[d-1];
    end

    always_comb begin
      div_next[d] = div_src[d];
      if (div_src[d].res &&
          (div_src[d].rem >= (mrb_pkg::CMP_W'(div_src[d].den) << SH))) begin
        div_next[d].rem     = div_src[d].rem - (mrb_pkg::CMP_W'(div_src[d].den) << SH);
        div_next[d].quo[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[d] <= 1'b0;
      end else if (advance) begin
        div_v[d] <= div_src_v[d];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        div_stage[d] <= div_next[d];
      end
    end
  end

  // saturate, then feed the binary to bcd conversion
  assign div_last = div_stage[RW-1];
  assign over     = div_last.sat || (div_last.quo > RW'(mrb_pkg::READING_MAX));

  always_comb begin
    bcd_first.unit = div_last.unit;
    bcd_first.ovf  = div_last.bad || over;
    bcd_first.bcd  = '0;
    priority if (div_last.bad) begin
      bcd_first.bin = '0;
    end else if (over) begin
      bcd_first.bin = RW'(mrb_pkg::READING_MAX);
    end else begin
      bcd_first.bin = div_last.quo;
    end
  end

  // shift-and-add-3, BCD_STEPS bits per stage
  for (genvar j = 0; j < NB; j++) begin : g_bcd
    if (j == 0) begin : g_head
      assign bcd_src[j]   = bcd_first;
      assign bcd_src_v[j] = div_v[RW-1];
    end else begin : g_link
      assign bcd_src[j]   = bcd_stage[j-1];
      assign bcd_src_v[j] = bcd_v[j-1];
    end

    always_comb begin
      logic [mrb_pkg::BCD_W-1:0] b;
      logic [RW-1:0]             v;
      b = bcd_src[j].bcd;
      v = bcd_src[j].bin;
      for (int k = 0; k < mrb_pkg::BCD_STEPS; k++) begin
        if (j * mrb_pkg::BCD_STEPS + k < RW) begin
          for (int n = 0; n < mrb_pkg::NUM_DIGITS; n++) begin
            if (b[n*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W] >= mrb_pkg::DIGIT_W'(5)) begin
              b[n*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W] =
                b[n*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W] + mrb_pkg::DIGIT_W'(3);
            end
          end
          {b, v} = {b, v} << 1;
        end
      end
      bcd_next[j]     = bcd_src[j];
      bcd_next[j].bcd = b;
      bcd_next[j].bin = v;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        bcd_v[j] <= 1'b0;
      end else if (advance) begin
        bcd_v[j] <= bcd_src_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        bcd_stage[j] <= bcd_next[j];
      end
    end
  end

  assign res_q = bcd_stage[NB-1];

  assign reading_ch.valid            = bcd_v[NB-1];
  assign reading_ch.hundreds_digit   = res_q.bcd[4*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W];
  assign reading_ch.tens_digit       = res_q.bcd[3*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W];
  assign reading_ch.ones_digit       = res_q.bcd[2*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W];
  assign reading_ch.tenths_digit     = res_q.bcd[1*mrb_pkg::DIGIT_W +: mrb_pkg::DIGIT_W];
  assign reading_ch.hundredths_digit = res_q.bcd[0 +: mrb_pkg::DIGIT_W];
  assign reading_ch.unit_code        = res_q.unit;
  assign reading_ch.overflow         = res_q.ovf;

endmodule

FILE: src/meter_reading_to_bcd_top.sv
// Meter reading to BCD: each beat on sample_ch carries a mode and a raw converter
// sample; each beat on reading_ch returns the reading in hundredths of the unit as five
// decimal digits, a unit code and an overflow flag, in input order. One beat is taken
// per clock as long as reading_ch keeps ready high. A sample is taken into the front register
// with its product, then passes through the four-entry queue, the overflow check stage, the
// restoring divider (one quotient bit per stage) and the BCD stages. While reading_ch holds
// off, the whole back pipeline waits, the queue and the front register fill, and then
// sample_ch drops ready. Voltage and current modes use a Q16 gain and truncate;
// resistance modes divide exactly. Unused modes give zeros with overflow set, and
// out-of-range readings saturate to 999.99.
module meter_reading_to_bcd_top (
  input  logic      clk,
  input  logic      rst,
  mrb_in_if.sink    sample_ch,
  mrb_out_if.source reading_ch
);

  mrb_pkg::item_t front_item;
  logic           front_valid;
  logic           front_ready;
  mrb_pkg::item_t queue_item;
  logic           queue_valid;
  logic           queue_ready;

  mrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  mrb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (queue_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  mrb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (queue_item),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .reading_ch (reading_ch)
  );

endmodule
